@@ src/sequenced_jitter_buffer_core_assert.svh @@
// Assertion macros of the port checker of the jitter buffer.
`ifndef SEQUENCED_JITTER_BUFFER_CORE_ASSERT_SVH
`define SEQUENCED_JITTER_BUFFER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SJB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sjb assertion failed");

// Next-cycle implication, checked out of reset.
`define SJB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sjb assertion failed");

`endif

@@ src/sjb_pkg.sv @@
// Types and constants of the sequenced jitter buffer.
package sjb_pkg;

  localparam int SEQ_W      = 16;
  localparam int WORD_W     = 64;
  localparam int BYTES_W    = 7;
  localparam int TICK_W     = 10;
  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 3;
  localparam int BT_W       = 10;
  localparam int JT_W       = 14;
  localparam int MOD_W      = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W      = 17;

  localparam int SEQ_LSB    = 0;
  localparam int DATA_LSB   = 16;
  localparam int BYTES_LSB  = 80;
  localparam int TICK_LSB   = 87;
  localparam int IN_TDATA_W = 104;

  localparam int OUT_WORD_LSB  = 0;
  localparam int OUT_BYTES_LSB = 64;
  localparam int OUT_TDATA_W   = 72;

  localparam logic [BYTES_W-1:0] BYTES_LIMIT = 7'd64;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_TIME  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_JITTER_TIME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_MODULUS = 2'd2;

  localparam logic [BT_W-1:0]  BT_RESET  = 10'd60;
  localparam logic [JT_W-1:0]  JT_RESET  = 14'd360;
  localparam logic [MOD_W-1:0] MOD_RESET = 17'd256;

  localparam logic [5:0] DIV_STEPS = 6'd33;

  typedef enum logic [MODE_W-1:0] {
    MODE_DATA  = 2'd0,
    MODE_PLAY  = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_ACCEPTED      = 3'd0,
    STAT_OUT_OF_WINDOW = 3'd1,
    STAT_DUPLICATE     = 3'd2,
    STAT_DATA          = 3'd3,
    STAT_REPLAYED      = 3'd4,
    STAT_NO_DATA       = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_CNT_INIT,
    S_CNT,
    S_DIV_LOAD,
    S_DIV,
    S_IDLE,
    S_JUDGE,
    S_SLOT,
    S_WRITE,
    S_RES,
    S_PLAY,
    S_PLAY_CMP,
    S_EM_RD,
    S_EM_OUT
  } state_e;

  typedef struct packed {
    mode_e               mode;
    logic [SEQ_W-1:0]    seq;
    logic [WORD_W-1:0]   data;
    logic [BYTES_W-1:0]  bytes;
    logic                last;
    logic [TICK_W-1:0]   tick;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_t;

  typedef struct packed {
    status_e             status;
    logic [WORD_W-1:0]   word;
    logic [BYTES_W-1:0]  bytes;
    logic                last;
  } result_t;

endpackage

@@ src/sjb_front.sv @@
// Front end: accepts items, decodes them and queues them for the back end.
module sjb_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [sjb_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  input  logic [sjb_pkg::MODE_W-1:0]   s_axis_tuser,
  input  logic                         s_axis_tlast,
  input  logic                         pop_i,
  output sjb_pkg::queue_t              q_o
);
  import sjb_pkg::*;

  item_t       buf_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  item_t       in_item;
  logic        push;
  logic        pop;

  always_comb begin
    in_item.mode  = mode_e'(s_axis_tuser);
    in_item.seq   = s_axis_tdata[SEQ_LSB +: SEQ_W];
    in_item.data  = s_axis_tdata[DATA_LSB +: WORD_W];
    in_item.bytes = s_axis_tdata[BYTES_LSB +: BYTES_W];
    in_item.last  = s_axis_tlast;
    in_item.tick  = s_axis_tdata[TICK_LSB +: TICK_W];
  end

  assign s_axis_tready = (count_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = pop_i && (count_q != 2'd0);
  assign q_o.valid     = (count_q != 2'd0);
  assign q_o.item      = buf_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= in_item;
    end
  end

endmodule

@@ src/sjb_back.sv @@
// Back end: window checks, slot storage, play-out sequencing and result register.
module sjb_back #(
  parameter int MAX_SLOTS   = 16,
  parameter int FRAME_WORDS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sjb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sjb_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  sjb_pkg::queue_t               q_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output sjb_pkg::result_t              out_o
);
  import sjb_pkg::*;

  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
  localparam int WC_W      = $clog2(FRAME_WORDS + 2);
  localparam int WIDX_W    = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;
  localparam int MEM_DEPTH = MAX_SLOTS * FRAME_WORDS;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int OUT_WORDS = (FRAME_WORDS < 8) ? FRAME_WORDS : 8;
  localparam int MAX_BYTES = OUT_WORDS * 8;

  state_e               state_q, state_d;
  logic                 recalc_q, recalc_d;
  logic [BT_W-1:0]      bt_q;
  logic [JT_W-1:0]      jt_q;
  logic [MOD_W-1:0]     mod_q;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [14:0]          acc_q, acc_d;
  logic [1:0]           div_sel_q, div_sel_d;
  logic [5:0]           div_step_q, div_step_d;
  logic [32:0]          div_dvd_q, div_dvd_d;
  logic [MOD_W-1:0]     div_rem_q, div_rem_d;
  logic [31:0]          head_q, head_d;
  logic [MOD_W-1:0]     hmod_q, hmod_d;
  logic [MOD_W-1:0]     tmod_q, tmod_d;
  logic [SLOT_W-1:0]    hslot_q, hslot_d;
  logic [SLOT_W-1:0]    r32_q, r32_d;
  logic                 running_q, running_d;
  logic [31:0]          del_el_q, del_el_d;
  logic [31:0]          play_el_q, play_el_d;
  logic [WC_W-1:0]      wc_q, wc_d;
  status_e              verdict_q, verdict_d;
  logic [SLOT_W-1:0]    ws_q, ws_d;
  item_t                cur_q, cur_d;
  logic [MOD_W-1:0]     num_q, num_d;
  logic                 oow_q, oow_d;
  logic                 ovf_q, ovf_d;
  logic [41:0]          prod_q, prod_d;
  status_e              stat_q, stat_d;
  logic                 em_src_q, em_src_d;
  logic [SLOT_W-1:0]    em_slot_q, em_slot_d;
  logic [BYTES_W-1:0]   em_len_q, em_len_d;
  logic [3:0]           k_q, k_d;
  logic [BYTES_W-1:0]   rep_len_q, rep_len_d;
  logic [BYTES_W-1:0]   sl_q [MAX_SLOTS];
  logic [BYTES_W-1:0]   sl_d [MAX_SLOTS];
  result_t              out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  logic [WORD_W-1:0]    mem_q [MEM_DEPTH];
  logic [WORD_W-1:0]    rep_q [FRAME_WORDS];
  logic [WORD_W-1:0]    mem_rdata_q;
  logic [WORD_W-1:0]    rep_rdata_q;
  logic                 mem_we, mem_re, rep_we, rep_re;
  logic [MEM_AW-1:0]    mem_waddr, mem_raddr;
  logic [WIDX_W-1:0]    rep_waddr, rep_raddr;

  logic [BT_W-1:0]      bt_eff;
  logic [MOD_W-1:0]     mod_eff;
  logic [SLOT_W-1:0]    slot_idx;
  logic [SLOT_W-1:0]    sl_raddr;
  logic [BYTES_W-1:0]   sl_rd;

  assign bt_eff   = (bt_q == '0) ? BT_W'(1) : bt_q;
  assign mod_eff  = (mod_q == '0) ? MOD_W'(1) : mod_q;
  assign sl_raddr = (state_q == S_SLOT) ? slot_idx : hslot_q;
  assign sl_rd    = sl_q[sl_raddr];

  // slot of the frame from head slot plus offset, corrected when the head count wraps
  always_comb begin
    logic [CNT_W:0] t;
    logic [CNT_W:0] a;
    logic [CNT_W:0] b;
    t   = (CNT_W+1)'(hslot_q) + (CNT_W+1)'(num_q[CNT_W-1:0]);
    a   = (t >= (CNT_W+1)'(cnt_q)) ? t - (CNT_W+1)'(cnt_q) : t;
    b   = a;
    if (ovf_q) begin
      if (a >= (CNT_W+1)'(r32_q)) begin
        b = a - (CNT_W+1)'(r32_q);
      end else begin
        b = a + (CNT_W+1)'(cnt_q) - (CNT_W+1)'(r32_q);
      end
    end
    slot_idx = SLOT_W'(b);
  end

  always_comb begin
    logic              out_free;
    logic [MOD_W-1:0]  divisor;
    logic [MOD_W:0]    rem2;
    logic [MOD_W-1:0]  rem_n;
    logic [MOD_W:0]    seq_x;
    logic [MOD_W:0]    num_x;
    logic              oow;
    logic [32:0]       s33;
    logic [BYTES_W-1:0] len_eff;
    logic [3:0]        n_words;
    logic              k_last;

    state_d     = state_q;
    recalc_d    = recalc_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    div_sel_d   = div_sel_q;
    div_step_d  = div_step_q;
    div_dvd_d   = div_dvd_q;
    div_rem_d   = div_rem_q;
    head_d      = head_q;
    hmod_d      = hmod_q;
    tmod_d      = tmod_q;
    hslot_d     = hslot_q;
    r32_d       = r32_q;
    running_d   = running_q;
    del_el_d    = del_el_q;
    play_el_d   = play_el_q;
    wc_d        = wc_q;
    verdict_d   = verdict_q;
    ws_d        = ws_q;
    cur_d       = cur_q;
    num_d       = num_q;
    oow_d       = oow_q;
    ovf_d       = ovf_q;
    prod_d      = prod_q;
    stat_d      = stat_q;
    em_src_d    = em_src_q;
    em_slot_d   = em_slot_q;
    em_len_d    = em_len_q;
    k_d         = k_q;
    rep_len_d   = rep_len_q;
    sl_d        = sl_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    pop_o       = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = MEM_AW'(ws_q) * MEM_AW'(FRAME_WORDS) + MEM_AW'(wc_q);
    mem_re      = 1'b0;
    mem_raddr   = MEM_AW'(em_slot_q) * MEM_AW'(FRAME_WORDS) + MEM_AW'(k_q);
    rep_we      = 1'b0;
    rep_waddr   = WIDX_W'(k_q);
    rep_re      = 1'b0;
    rep_raddr   = WIDX_W'(k_q);

    out_free = !out_valid_q || out_ready_i;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    divisor = (div_sel_q[1]) ? MOD_W'(cnt_q) : mod_eff;
    rem2    = {div_rem_q, div_dvd_q[32]};
    rem_n   = (rem2 >= {1'b0, divisor}) ? MOD_W'(rem2 - {1'b0, divisor}) : MOD_W'(rem2);

    seq_x = (MOD_W+1)'(cur_q.seq);
    oow   = 1'b0;
    if (seq_x >= (MOD_W+1)'(mod_eff)) begin
      oow = 1'b1;
    end else if (hmod_q < tmod_q) begin
      oow = (seq_x < (MOD_W+1)'(hmod_q)) || (seq_x >= (MOD_W+1)'(tmod_q));
    end else begin
      oow = (seq_x >= (MOD_W+1)'(tmod_q)) && (seq_x < (MOD_W+1)'(hmod_q));
    end
    num_x = (seq_x >= (MOD_W+1)'(hmod_q)) ? seq_x - (MOD_W+1)'(hmod_q)
          : seq_x + (MOD_W+1)'(mod_eff) - (MOD_W+1)'(hmod_q);

    len_eff = cur_q.bytes;
    if (len_eff == '0) begin
      len_eff = BYTES_W'(1);
    end else if (len_eff > BYTES_W'(MAX_BYTES)) begin
      len_eff = BYTES_W'(MAX_BYTES);
    end

    n_words = 4'((em_len_q + BYTES_W'(7)) >> 3);
    k_last  = ((k_q + 4'd1) == n_words);
    s33     = '0;

    unique case (state_q)
      S_CNT_INIT: begin
        acc_d   = 15'(bt_eff);
        cnt_d   = CNT_W'(1);
        state_d = S_CNT;
      end
      S_CNT: begin
        if ((cnt_q < CNT_W'(MAX_SLOTS)) && (acc_q <= 15'(jt_q))) begin
          acc_d = acc_q + 15'(bt_eff);
          cnt_d = cnt_q + CNT_W'(1);
        end else begin
          div_sel_d = 2'd0;
          state_d   = S_DIV_LOAD;
        end
      end
      S_DIV_LOAD: begin
        div_rem_d  = '0;
        div_step_d = DIV_STEPS;
        unique case (div_sel_q)
          2'd0:    div_dvd_d = {1'b0, head_q};
          2'd1:    div_dvd_d = {1'b0, head_q + 32'(cnt_q)};
          2'd2:    div_dvd_d = {1'b0, head_q};
          default: div_dvd_d = {1'b1, 32'd0};
        endcase
        state_d = S_DIV;
      end
      S_DIV: begin
        div_rem_d  = rem_n;
        div_dvd_d  = {div_dvd_q[31:0], 1'b0};
        div_step_d = div_step_q - 6'd1;
        if (div_step_q == 6'd1) begin
          unique case (div_sel_q)
            2'd0:    hmod_d  = rem_n;
            2'd1:    tmod_d  = rem_n;
            2'd2:    hslot_d = SLOT_W'(rem_n);
            default: r32_d   = SLOT_W'(rem_n);
          endcase
          div_sel_d = div_sel_q + 2'd1;
          state_d   = (div_sel_q == 2'd3) ? S_IDLE : S_DIV_LOAD;
        end
      end
      S_IDLE: begin
        if (recalc_q) begin
          recalc_d = 1'b0;
          state_d  = S_CNT_INIT;
        end else if (q_i.valid) begin
          pop_o = 1'b1;
          cur_d = q_i.item;
          unique case (q_i.item.mode)
            MODE_DATA: begin
              state_d = (wc_q == '0) ? S_JUDGE : S_WRITE;
            end
            MODE_PLAY: begin
              state_d = S_PLAY;
            end
            MODE_TICK: begin
              if (running_q) begin
                s33      = {1'b0, del_el_q} + 33'(q_i.item.tick);
                del_el_d = s33[32] ? '1 : s33[31:0];
              end
              s33       = {1'b0, play_el_q} + 33'(q_i.item.tick);
              play_el_d = s33[32] ? '1 : s33[31:0];
            end
            MODE_CLEAR: begin
              for (int i = 0; i < MAX_SLOTS; i++) begin
                sl_d[i] = '0;
              end
              head_d    = '0;
              rep_len_d = '0;
              running_d = 1'b0;
              del_el_d  = '0;
              wc_d      = '0;
              verdict_d = STAT_ACCEPTED;
              ws_d      = '0;
              state_d   = S_CNT_INIT;
            end
          endcase
        end
      end
      S_JUDGE: begin
        oow_d   = oow;
        num_d   = MOD_W'(num_x);
        s33     = {1'b0, head_q} + 33'(num_x);
        ovf_d   = s33[32];
        state_d = S_SLOT;
      end
      S_SLOT: begin
        if (oow_q) begin
          verdict_d = STAT_OUT_OF_WINDOW;
          state_d   = S_WRITE;
        end else if (num_q >= MOD_W'(cnt_q)) begin
          num_d = num_q - MOD_W'(cnt_q);
        end else if (sl_rd != '0) begin
          verdict_d = STAT_DUPLICATE;
          state_d   = S_WRITE;
        end else begin
          verdict_d = STAT_ACCEPTED;
          ws_d      = slot_idx;
          state_d   = S_WRITE;
        end
      end
      S_WRITE: begin
        if ((verdict_q == STAT_ACCEPTED) && (wc_q < WC_W'(FRAME_WORDS))) begin
          mem_we = 1'b1;
        end
        if (wc_q < WC_W'(FRAME_WORDS + 1)) begin
          wc_d = wc_q + WC_W'(1);
        end
        if (!cur_q.last) begin
          state_d = S_IDLE;
        end else begin
          if (verdict_q == STAT_ACCEPTED) begin
            sl_d[ws_q] = len_eff;
            if (!running_q) begin
              running_d = 1'b1;
              del_el_d  = '0;
            end
          end
          wc_d    = '0;
          stat_d  = verdict_q;
          state_d = S_RES;
        end
      end
      S_RES: begin
        if (out_free) begin
          out_d.status = stat_q;
          out_d.word   = '0;
          out_d.bytes  = '0;
          out_d.last   = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_PLAY: begin
        if (!running_q || (del_el_q < 32'(jt_q))) begin
          play_el_d = '0;
          stat_d    = STAT_NO_DATA;
          state_d   = S_RES;
        end else begin
          prod_d  = head_q * bt_eff;
          state_d = S_PLAY_CMP;
        end
      end
      S_PLAY_CMP: begin
        if (prod_q > 42'(play_el_q)) begin
          stat_d  = STAT_NO_DATA;
          state_d = S_RES;
        end else begin
          head_d = head_q + 32'd1;
          if (head_q == '1) begin
            hmod_d  = '0;
            hslot_d = '0;
          end else begin
            hmod_d  = ((hmod_q + MOD_W'(1)) == mod_eff) ? '0 : hmod_q + MOD_W'(1);
            hslot_d = ((CNT_W'(hslot_q) + CNT_W'(1)) == cnt_q) ? '0
                    : hslot_q + SLOT_W'(1);
          end
          if ((head_q + 32'(cnt_q)) == '1) begin
            tmod_d = '0;
          end else begin
            tmod_d = ((tmod_q + MOD_W'(1)) == mod_eff) ? '0 : tmod_q + MOD_W'(1);
          end
          k_d       = '0;
          em_slot_d = hslot_q;
          if (sl_rd != '0) begin
            sl_d[hslot_q] = '0;
            rep_len_d     = sl_rd;
            em_src_d      = 1'b1;
            em_len_d      = sl_rd;
            stat_d        = STAT_DATA;
            state_d       = S_EM_RD;
          end else if (rep_len_q != '0) begin
            em_src_d = 1'b0;
            em_len_d = rep_len_q;
            stat_d   = STAT_REPLAYED;
            state_d  = S_EM_RD;
          end else begin
            stat_d  = STAT_NO_DATA;
            state_d = S_RES;
          end
        end
      end
      S_EM_RD: begin
        mem_re  = 1'b1;
        rep_re  = 1'b1;
        state_d = S_EM_OUT;
      end
      S_EM_OUT: begin
        if (out_free) begin
          out_d.status = stat_q;
          out_d.word   = em_src_q ? mem_rdata_q : rep_rdata_q;
          out_d.bytes  = em_len_q;
          out_d.last   = k_last;
          out_valid_d  = 1'b1;
          rep_we       = em_src_q;
          k_d          = k_q + 4'd1;
          state_d      = k_last ? S_IDLE : S_EM_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      recalc_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bt_q  <= BT_RESET;
      jt_q  <= JT_RESET;
      mod_q <= MOD_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BLOCK_TIME:  bt_q  <= cfg_wdata_i[BT_W-1:0];
        CFG_JITTER_TIME: jt_q  <= cfg_wdata_i[JT_W-1:0];
        CFG_SEQ_MODULUS: mod_q <= cfg_wdata_i[MOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CNT_INIT;
      recalc_q    <= 1'b0;
      cnt_q       <= CNT_W'(1);
      acc_q       <= '0;
      div_sel_q   <= '0;
      div_step_q  <= '0;
      div_dvd_q   <= '0;
      div_rem_q   <= '0;
      head_q      <= '0;
      hmod_q      <= '0;
      tmod_q      <= '0;
      hslot_q     <= '0;
      r32_q       <= '0;
      running_q   <= 1'b0;
      del_el_q    <= '0;
      play_el_q   <= '0;
      wc_q        <= '0;
      verdict_q   <= STAT_ACCEPTED;
      ws_q        <= '0;
      cur_q       <= '0;
      num_q       <= '0;
      oow_q       <= 1'b0;
      ovf_q       <= 1'b0;
      prod_q      <= '0;
      stat_q      <= STAT_NO_DATA;
      em_src_q    <= 1'b0;
      em_slot_q   <= '0;
      em_len_q    <= '0;
      k_q         <= '0;
      rep_len_q   <= '0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        sl_q[i] <= '0;
      end
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      recalc_q    <= recalc_d;
      cnt_q       <= cnt_d;
      acc_q       <= acc_d;
      div_sel_q   <= div_sel_d;
      div_step_q  <= div_step_d;
      div_dvd_q   <= div_dvd_d;
      div_rem_q   <= div_rem_d;
      head_q      <= head_d;
      hmod_q      <= hmod_d;
      tmod_q      <= tmod_d;
      hslot_q     <= hslot_d;
      r32_q       <= r32_d;
      running_q   <= running_d;
      del_el_q    <= del_el_d;
      play_el_q   <= play_el_d;
      wc_q        <= wc_d;
      verdict_q   <= verdict_d;
      ws_q        <= ws_d;
      cur_q       <= cur_d;
      num_q       <= num_d;
      oow_q       <= oow_d;
      ovf_q       <= ovf_d;
      prod_q      <= prod_d;
      stat_q      <= stat_d;
      em_src_q    <= em_src_d;
      em_slot_q   <= em_slot_d;
      em_len_q    <= em_len_d;
      k_q         <= k_d;
      rep_len_q   <= rep_len_d;
      sl_q        <= sl_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= cur_q.data;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rep_we) begin
      rep_q[rep_waddr] <= mem_rdata_q;
    end
    if (rep_re) begin
      rep_rdata_q <= rep_q[rep_raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

@@ src/sequenced_jitter_buffer_core.sv @@
// Sequenced jitter buffer top level: front queue, back engine and stream ports.
// Reorders sequence-numbered voice frames into MAX_SLOTS slots of FRAME_WORDS
// 64-bit words. A front queue of two items takes input while the back engine
// works; the engine handles one item at a time. The first data word of a
// frame is judged against the window and its slot is found (the window offset
// loses one slot count per step while it is not below the slot count) before
// the word is written; a last data word adds a status item; a request that
// plays a frame emits each word through a read state and an output state, set
// by the registered read of the slot memory. After reset, every configuration
// write and every clear, the engine computes the slot count and four 33-step
// serial remainders (head and head plus slot count modulo the sequence modulus,
// head and 2^32 modulo the slot count) before it takes the next item.
module sequenced_jitter_buffer_core #(
  parameter int MAX_SLOTS   = 16,
  parameter int FRAME_WORDS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // seq_number, data_word, frame_bytes, tick_ms, zero pad
  input  logic [sjb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // mode
  input  logic [sjb_pkg::MODE_W-1:0]      s_axis_tuser,
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // out_word, out_bytes, zero pad
  output logic [sjb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // status
  output logic [sjb_pkg::STATUS_W-1:0]    m_axis_tuser,
  output logic                            m_axis_tlast,
  input  logic                            cfg_we_i,
  input  logic [sjb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sjb_pkg::CFG_W-1:0]       cfg_wdata_i
);
  import sjb_pkg::*;

  queue_t  q;
  logic    pop;
  result_t res;

  sjb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .pop_i         (pop),
    .q_o           (q)
  );

  sjb_back #(
    .MAX_SLOTS   (MAX_SLOTS),
    .FRAME_WORDS (FRAME_WORDS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_i         (q),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - WORD_W - BYTES_W)'(0), res.bytes, res.word};
  assign m_axis_tuser = res.status;
  assign m_axis_tlast = res.last;

endmodule

@@ src/sjb_checker.sv @@
// Port-level checks of the jitter buffer result stream, bound to the top level.
`include "sequenced_jitter_buffer_core_assert.svh"

module sjb_port_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [sjb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [sjb_pkg::STATUS_W-1:0]    m_axis_tuser,
  input logic                            m_axis_tlast
);
  import sjb_pkg::*;

  `SJB_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
  `SJB_ASSERT_IMP(a_status_range, m_axis_tvalid, m_axis_tuser <= STAT_NO_DATA)
  `SJB_ASSERT_IMP(a_status_only, m_axis_tvalid && (m_axis_tuser == STAT_ACCEPTED ||
    m_axis_tuser == STAT_OUT_OF_WINDOW || m_axis_tuser == STAT_DUPLICATE ||
    m_axis_tuser == STAT_NO_DATA), m_axis_tlast &&
    m_axis_tdata[OUT_BYTES_LSB +: BYTES_W] == '0 && m_axis_tdata[OUT_WORD_LSB +: WORD_W] == '0)
  `SJB_ASSERT_IMP(a_frame_len, m_axis_tvalid && (m_axis_tuser == STAT_DATA ||
    m_axis_tuser == STAT_REPLAYED), m_axis_tdata[OUT_BYTES_LSB +: BYTES_W] != '0 &&
    m_axis_tdata[OUT_BYTES_LSB +: BYTES_W] <= BYTES_LIMIT)

endmodule

bind sequenced_jitter_buffer_core sjb_port_checker u_sjb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

@@ tb/sjb_checker.sv @@
// Checker of the jitter buffer: watches both streams, predicts every result item and compares.
module sjb_checker
  import sjb_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  input  logic                     s_axis_tready,
  input  logic [IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic [MODE_W-1:0]        s_axis_tuser,
  input  logic                     s_axis_tlast,
  input  logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  input  logic [OUT_TDATA_W-1:0]   m_axis_tdata,
  input  logic [STATUS_W-1:0]      m_axis_tuser,
  input  logic                     m_axis_tlast,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_W-1:0]         cfg_wdata_i,
  output int                       errors_o,
  output int                       pending_o,
  output logic [31:0]              head_o
);

  localparam int SLOTS  = 16;
  localparam int FWORDS = 8;

  logic [BT_W-1:0]    blk_ms;
  logic [JT_W-1:0]    jit_ms;
  logic [MOD_W-1:0]   seq_mod;

  logic [WORD_W-1:0]  slot_mem [SLOTS*FWORDS];
  logic [6:0]         slot_len [SLOTS];
  logic [WORD_W-1:0]  replay_mem [FWORDS];
  logic [6:0]         replay_len;
  logic [31:0]        head_cnt;
  logic               delay_on;
  logic [31:0]        delay_ms;
  logic [31:0]        play_ms;
  logic [31:0]        wr_slot;
  logic [31:0]        wr_words;
  status_e            wr_verdict;

  result_t            expected_q[$];

  assign pending_o = expected_q.size();
  assign head_o    = head_cnt;

  function automatic logic [31:0] window_slots();
    logic [31:0] bt;
    logic [31:0] c;
    bt = (blk_ms == 0) ? 32'd1 : 32'(blk_ms);
    c  = 32'(jit_ms) / bt + 32'd1;
    return (c > SLOTS) ? 32'(SLOTS) : c;
  endfunction

  function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  task automatic drop_buffer();
    for (int i = 0; i < SLOTS; i++) slot_len[i] = '0;
    head_cnt   = '0;
    replay_len = '0;
    delay_on   = 1'b0;
    delay_ms   = '0;
    wr_slot    = '0;
    wr_words   = '0;
    wr_verdict = STAT_ACCEPTED;
  endtask

  task automatic judge(logic [31:0] seq);
    logic [31:0] md, cnt, hd, tl, num, idx;
    md  = (seq_mod == 0) ? 32'd1 : 32'(seq_mod);
    cnt = window_slots();
    hd  = head_cnt % md;
    tl  = (head_cnt + cnt) % md;
    if (seq >= md) begin
      wr_verdict = STAT_OUT_OF_WINDOW;
      return;
    end
    if (hd < tl) begin
      if (seq < hd || seq >= tl) begin
        wr_verdict = STAT_OUT_OF_WINDOW;
        return;
      end
    end else if (seq >= tl && seq < hd) begin
      wr_verdict = STAT_OUT_OF_WINDOW;
      return;
    end
    num = (seq >= hd) ? seq - hd : seq + md - hd;
    idx = (head_cnt + num) % cnt;
    if (slot_len[idx] > 0) begin
      wr_verdict = STAT_DUPLICATE;
      return;
    end
    wr_verdict = STAT_ACCEPTED;
    wr_slot    = idx;
  endtask

  task automatic push_play(status_e st, logic [6:0] len);
    int n;
    result_t r;
    n = (int'(len) + 7) / 8;
    if (n == 0) begin
      r = '{status: st, word: '0, bytes: '0, last: 1'b1};
      expected_q.push_back(r);
    end
    for (int k = 0; k < n; k++) begin
      r = '{status: st, word: replay_mem[k], bytes: len, last: (k == n - 1)};
      expected_q.push_back(r);
    end
  endtask

  task automatic take_item(item_t it);
    logic [31:0] bt, idx, len;
    result_t r;
    case (it.mode)
      MODE_DATA: begin
        if (wr_words == 0) judge(32'(it.seq));
        if (wr_verdict == STAT_ACCEPTED && wr_words < FWORDS)
          slot_mem[wr_slot*FWORDS + wr_words] = it.data;
        if (wr_words < FWORDS + 1) wr_words++;
        if (it.last) begin
          if (wr_verdict == STAT_ACCEPTED) begin
            len = 32'(it.bytes);
            if (len == 0) len = 1;
            if (len > 64) len = 64;
            slot_len[wr_slot] = len[6:0];
            if (!delay_on) begin
              delay_on = 1'b1;
              delay_ms = '0;
            end
          end
          wr_words = '0;
          r = '{status: wr_verdict, word: '0, bytes: '0, last: 1'b1};
          expected_q.push_back(r);
        end
      end
      MODE_PLAY: begin
        bt = (blk_ms == 0) ? 32'd1 : 32'(blk_ms);
        if (!delay_on || delay_ms < 32'(jit_ms)) begin
          play_ms = '0;
          push_play(STAT_NO_DATA, '0);
        end else if (head_cnt > play_ms / bt) begin
          push_play(STAT_NO_DATA, '0);
        end else begin
          idx = head_cnt % window_slots();
          head_cnt++;
          if (slot_len[idx] > 0) begin
            for (int k = 0; k < FWORDS; k++) replay_mem[k] = slot_mem[idx*FWORDS + k];
            replay_len    = slot_len[idx];
            slot_len[idx] = '0;
            push_play(STAT_DATA, replay_len);
          end else if (replay_len > 0) begin
            push_play(STAT_REPLAYED, replay_len);
          end else begin
            push_play(STAT_NO_DATA, '0);
          end
        end
      end
      MODE_TICK: begin
        if (delay_on) delay_ms = sat_sum(delay_ms, 32'(it.tick));
        play_ms = sat_sum(play_ms, 32'(it.tick));
      end
      default: drop_buffer();
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    item_t   it;
    result_t got, want;
    if (!rst_ni) begin
      blk_ms  = BT_RESET;
      jit_ms  = JT_RESET;
      seq_mod = MOD_RESET;
      for (int i = 0; i < SLOTS*FWORDS; i++) slot_mem[i] = '0;
      for (int i = 0; i < FWORDS; i++) replay_mem[i] = '0;
      play_ms = '0;
      drop_buffer();
      expected_q.delete();
      errors_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = status_e'(m_axis_tuser);
        got.word   = m_axis_tdata[OUT_WORD_LSB +: WORD_W];
        got.bytes  = m_axis_tdata[OUT_BYTES_LSB +: BYTES_W];
        got.last   = m_axis_tlast;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result item, actual %p", $time, got);
          errors_o++;
        end else begin
          want = expected_q.pop_front();
          if (got.status !== want.status || got.word !== want.word ||
              got.bytes !== want.bytes || got.last !== want.last) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
            errors_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        it.mode  = mode_e'(s_axis_tuser);
        it.seq   = s_axis_tdata[SEQ_LSB +: SEQ_W];
        it.data  = s_axis_tdata[DATA_LSB +: WORD_W];
        it.bytes = s_axis_tdata[BYTES_LSB +: BYTES_W];
        it.last  = s_axis_tlast;
        it.tick  = s_axis_tdata[TICK_LSB +: TICK_W];
        take_item(it);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BLOCK_TIME:  blk_ms  = cfg_wdata_i[BT_W-1:0];
          CFG_JITTER_TIME: jit_ms  = cfg_wdata_i[JT_W-1:0];
          CFG_SEQ_MODULUS: seq_mod = cfg_wdata_i[MOD_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

@@ tb/tb_sequenced_jitter_buffer_core.sv @@
// Testbench top of the jitter buffer: clock, reset, stimulus, configuration and verdict.
module tb_sequenced_jitter_buffer_core;
  import sjb_pkg::*;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [MODE_W-1:0]      s_axis_tuser = MODE_TICK;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]    m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = CFG_BLOCK_TIME;
  logic [CFG_W-1:0]       cfg_wdata_i = '0;

  int                     errors;
  int                     pending;
  logic [31:0]            head_cnt;
  bit                     burst = 1'b0;
  int                     sent = 0;
  logic [31:0]            blk_ms = BT_RESET;
  logic [31:0]            jit_ms = JT_RESET;
  logic [31:0]            seq_mod = MOD_RESET;

  always #1 clk_i = ~clk_i;

  sequenced_jitter_buffer_core i_dut (.*);

  sjb_checker i_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .s_axis_tlast, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .m_axis_tlast, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .errors_o(errors), .pending_o(pending), .head_o(head_cnt)
  );

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  // Drain side: outside burst mode, may hold ready low before each result item.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      n = burst ? 0 : $urandom_range(0, 6);
      if (n > 0) begin
        m_axis_tready = 1'b0;
        repeat (n) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  task automatic send(mode_e md, logic [15:0] seq, logic [63:0] data, logic [6:0] nbytes,
                      logic lst, logic [9:0] tick);
    int n;
    n = burst ? 0 : $urandom_range(0, 6);
    if (n > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (n) @(negedge clk_i);
    end
    s_axis_tuser  = md;
    s_axis_tlast  = lst;
    s_axis_tdata  = '0;
    s_axis_tdata[SEQ_LSB +: SEQ_W]    = seq;
    s_axis_tdata[DATA_LSB +: WORD_W]  = data;
    s_axis_tdata[BYTES_LSB +: BYTES_W] = nbytes;
    s_axis_tdata[TICK_LSB +: TICK_W]  = tick;
    s_axis_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
    if ($urandom_range(0, 15) == 0) burst = ~burst;
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  task automatic simple(mode_e md, logic [9:0] tick);
    send(md, 16'($urandom()), rand_word(), 7'($urandom()), 1'($urandom()), tick);
  endtask

  // Length never points past the words written, so no unwritten word is played.
  task automatic frame(logic [15:0] seq, int nwords, logic [6:0] nbytes, bit noisy);
    for (int w = 0; w < nwords; w++) begin
      if (noisy && $urandom_range(0, 9) == 0)
        simple($urandom_range(0, 1) ? MODE_PLAY : MODE_TICK, 10'($urandom_range(0, 1000)));
      send(MODE_DATA, (w == 0) ? seq : 16'($urandom()), rand_word(),
           (w == nwords - 1) ? nbytes : 7'($urandom()), w == nwords - 1,
           10'($urandom()));
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  task automatic configure(logic [31:0] bt, logic [31:0] jt, logic [31:0] md);
    logic [31:0] vals [3];
    vals = '{bt, jt, md};
    wait_drained();
    for (int i = 0; i < 3; i++) begin
      cfg_we_i    = 1'b1;
      cfg_idx_i   = CFG_IDX_W'(i);
      cfg_wdata_i = vals[i][CFG_W-1:0];
      @(negedge clk_i);
    end
    cfg_we_i = 1'b0;
    blk_ms   = bt;
    jit_ms   = jt;
    seq_mod  = md;
  endtask

  task automatic random_phase(int count);
    int r, nw, cnt, md, lim, ticks_bt;
    logic [15:0] seq;
    logic [6:0] nb;
    while (sent < count) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        cnt = jit_ms / ((blk_ms == 0) ? 1 : blk_ms) + 1;
        if (cnt > 16) cnt = 16;
        md = (seq_mod == 0) ? 1 : seq_mod;
        if ($urandom_range(0, 99) < 85)
          seq = 16'((head_cnt + $urandom_range(0, cnt)) % md);
        else
          seq = 16'($urandom());
        nw  = $urandom_range(0, 3) == 0 ? $urandom_range(8, 10) : $urandom_range(1, 3);
        lim = (nw >= 8) ? 127 : 8 * nw;
        nb  = 7'($urandom_range(0, lim));
        if (nb == 0 && nw < 1) nb = 1;
        frame(seq, nw, nb, 1'b1);
        if ($urandom_range(0, 40) == 0) simple(MODE_CLEAR, '0);
      end else if (r < 75) begin
        ticks_bt = (blk_ms > 1000 || blk_ms == 0) ? 1000 : blk_ms;
        simple(MODE_TICK, 10'($urandom_range(0, 1) ? $urandom_range(0, 1000)
                                                    : $urandom_range(0, ticks_bt)));
      end else if (r < 97) begin
        simple(MODE_PLAY, '0);
      end else begin
        simple(MODE_CLEAR, '0);
      end
    end
  endtask

  initial begin
    int deadline;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed item sequence at reset settings.
    frame(16'd0, 1, 7'd0, 1'b0);
    frame(16'd1, 10, 7'd127, 1'b0);
    frame(16'd0, 1, 7'd8, 1'b0);
    frame(16'hFFFF, 2, 7'd16, 1'b0);
    frame(16'd300, 1, 7'd1, 1'b0);
    simple(MODE_PLAY, '0);
    simple(MODE_TICK, 10'd1000);
    simple(MODE_TICK, 10'd0);
    simple(MODE_PLAY, '0);
    simple(MODE_TICK, 10'd511);
    simple(MODE_PLAY, '0);
    send(MODE_DATA, 16'd3, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64, 1'b0, 10'd0);
    simple(MODE_PLAY, '0);
    send(MODE_DATA, 16'd0, 64'd0, 7'd16, 1'b1, 10'd0);
    simple(MODE_TICK, 10'd512);
    simple(MODE_PLAY, '0);
    simple(MODE_PLAY, '0);
    send(MODE_DATA, 16'd5, 64'h0123_4567_89AB_CDEF, 7'd8, 1'b0, 10'd0);
    simple(MODE_CLEAR, '0);
    frame(16'd0, 1, 7'd4, 1'b0);
    simple(MODE_CLEAR, '0);

    random_phase(90);
    configure(1000, 10000, 65536);
    random_phase(155);
    configure(1, 1, 1);
    random_phase(215);
    configure(0, 0, 0);
    random_phase(265);
    configure(20, 100, 16);
    random_phase(340);
    configure(7, 300, 100);
    random_phase(420);

    s_axis_tvalid = 1'b0;
    deadline = 0;
    while (pending != 0 && deadline < 100000) begin
      @(negedge clk_i);
      deadline++;
    end
    repeat (200) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
